>>> src/ffa_pkg.sv
// Shared types and constants of the first-fit block allocator.
`default_nettype none

package ffa_pkg;

    // Blocks held in one word of the used map
    localparam int MAP_W = 8;

    // Parameter defaults and register reset value
    localparam int          NUM_BLOCKS_DEF  = 256;
    localparam int          BLOCK_BYTES_DEF = 16;
    localparam logic [31:0] HEAP_BASE_RST   = 32'h2000_1000;

    // Request kinds carried on the input tuser
    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NOP   = 2'd3
    } t_mode;

    // Result status carried on the output tuser
    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_ZERO    = 2'd1,
        STAT_NOSPACE = 2'd2,
        STAT_IGNORED = 2'd3
    } t_status;

    // Controller states
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_SCAN,
        S_MARK_RD,
        S_MARK,
        S_ADDR,
        S_FREE,
        S_WIPE,
        S_RESP
    } t_state;

endpackage

`default_nettype wire

>>> src/ffa_map.sv
// Used-map memory: one write port, one registered read port.
`default_nettype none

module ffa_map #(
    parameter int NW = 32,
    parameter int AW = 5,
    parameter int W  = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [W-1:0]  o_rd_data,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [W-1:0]  i_wr_data
);

    logic [W-1:0] r_mem [NW];
    logic [W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> src/ffa_div.sv
// Division by the block size: multiply by a rounded-up reciprocal, quotient registered in the cycle after start.
`default_nettype none

module ffa_div #(
    parameter int DW          = 13,
    parameter int CW          = 9,
    parameter int BLOCK_BYTES = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    output logic               o_done,
    output logic      [CW-1:0] o_quot
);

    // quotient = (dividend * MULT) >> SH; the rounding error of MULT stays below one
    // block for every DW-bit dividend, so the truncated product is the exact quotient
    localparam int              LW   = $clog2(BLOCK_BYTES);
    localparam int              SH   = DW + LW;
    localparam int              MW   = DW + 1;
    localparam int              PW   = DW + MW;
    localparam longint unsigned ONE  = 1;
    localparam logic [MW-1:0]   MULT = MW'(((ONE << SH) + BLOCK_BYTES - 1) / BLOCK_BYTES);

    logic [PW-1:0] w_prod;
    logic [CW-1:0] r_quot;
    logic          r_done;

    assign w_prod = {{MW{1'b0}}, i_dividend} * {{DW{1'b0}}, MULT};

    // done flag, registered from start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    // quotient register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= CW'(w_prod >> SH);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

>>> src/first_fit_block_allocator.sv
// Top level of the first-fit bitmap block allocator.
// One request per input beat, one result beat per request; a new request is taken only
// after the previous one has finished. The used map lives in a memory of MAP_W-bit words
// (NW = ceil(NUM_BLOCKS / 8) words); allocates and frees walk it one word per cycle through
// the single read port, each word written back in the cycle after its read. Byte counts and
// free offsets become block numbers through a registered reciprocal multiply. A result
// that is still waiting in the output register holds the block in its last step until it is
// taken. After reset the block runs a clearing pass over all NW words (32 by default)
// before it takes the first request; heap_base should be written only while no request
// is in flight.
`default_nettype none

module first_fit_block_allocator #(
    parameter int NUM_BLOCKS  = ffa_pkg::NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = ffa_pkg::BLOCK_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration: heap_base
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data,
    // request stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [47:0] i_s_tdata,  // [15:0] alloc_bytes, [47:16] free_address
    input  wire logic [1:0]  i_s_tuser,  // [1:0] mode
    // result stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [31:0] o_m_tdata,  // [31:0] block_address
    output logic      [1:0]  o_m_tuser   // [1:0] status
);

    localparam int W          = ffa_pkg::MAP_W;
    localparam int BW         = $clog2(W);
    localparam int NW         = (NUM_BLOCKS + W - 1) / W;
    localparam int AW         = (NW > 1) ? $clog2(NW) : 1;
    localparam int CW         = $clog2(NUM_BLOCKS + 1);
    localparam int XW         = ((AW + BW) > CW) ? (AW + BW) : CW;
    localparam int HEAP_BYTES = NUM_BLOCKS * BLOCK_BYTES;
    localparam int DW         = $clog2((NUM_BLOCKS + 1) * BLOCK_BYTES);

    ffa_pkg::t_state  r_state, n_state;
    ffa_pkg::t_mode   r_mode;
    ffa_pkg::t_status r_status;

    logic [31:0]   r_heap_base;
    logic [15:0]   r_bytes;
    logic [31:0]   r_faddr;
    logic [AW-1:0] r_word;
    logic [XW-1:0] r_needed;
    logic [XW-1:0] r_count;
    logic [XW-1:0] r_start;
    logic [XW-1:0] r_end;
    logic [31:0]   r_offs;
    logic [31:0]   r_res_addr;
    logic          r_ovalid;
    logic [31:0]   r_oaddr;
    logic [1:0]    r_ostat;

    // map and divider hookup
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic [W-1:0]  w_rd_data;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [W-1:0]  w_wr_data;
    logic          w_div_start;
    logic [DW-1:0] w_div_dvd;
    logic          w_div_done;
    logic [CW-1:0] w_div_q;

    // decode helpers
    logic [31:0]   w_off;
    logic          w_free_bad;
    logic          w_alloc_big;
    logic [XW-1:0] w_q;
    logic          w_last_word;
    logic          w_take;
    logic          w_accept;

    // per-word results
    logic          w_found;
    logic [XW-1:0] w_scan_start;
    logic [XW-1:0] w_scan_count;
    logic [W-1:0]  w_mark_mask;
    logic [W-1:0]  w_free_clr;
    logic          w_free_more;

    ffa_map #(
        .NW (NW),
        .AW (AW),
        .W  (W)
    ) u_map (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    ffa_div #(
        .DW          (DW),
        .CW          (CW),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .o_done     (w_div_done),
        .o_quot     (w_div_q)
    );

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == ffa_pkg::S_IDLE);
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_take      = !r_ovalid || i_m_tready;
    assign w_last_word = (r_word == AW'(NW - 1));
    assign w_q         = XW'(w_div_q);

    // request checks
    assign w_off       = r_faddr - r_heap_base;
    assign w_free_bad  = (r_faddr == 32'd0) || (r_faddr < r_heap_base) ||
                         (w_off >= 32'(HEAP_BYTES));
    assign w_alloc_big = (32'(r_bytes) > 32'(HEAP_BYTES));

    // first-fit scan of one word; blocks past the heap count as used
    always_comb begin
        logic [XW-1:0] idx;
        logic          used;
        w_found      = 1'b0;
        w_scan_start = r_start;
        w_scan_count = r_count;
        for (int b = 0; b < W; b++) begin
            idx  = XW'({r_word, BW'(b)});
            used = w_rd_data[b] || (idx >= XW'(NUM_BLOCKS));
            if (!w_found) begin
                if (!used) begin
                    if (w_scan_count == '0) begin
                        w_scan_start = idx;
                    end
                    w_scan_count = w_scan_count + XW'(1);
                    if (w_scan_count == r_needed) begin
                        w_found = 1'b1;
                    end
                end else begin
                    w_scan_count = '0;
                end
            end
        end
    end

    // bits of this word that fall inside the chosen run
    always_comb begin
        logic [XW-1:0] idx;
        for (int b = 0; b < W; b++) begin
            idx            = XW'({r_word, BW'(b)});
            w_mark_mask[b] = (idx >= r_start) && (idx <= r_end);
        end
    end

    // free walk: clear used blocks from the start up to the first free one
    always_comb begin
        logic [XW-1:0] idx;
        logic          stop;
        stop       = 1'b0;
        w_free_clr = '0;
        for (int b = 0; b < W; b++) begin
            idx = XW'({r_word, BW'(b)});
            if (!stop && idx >= r_start) begin
                if (w_rd_data[b] && idx < XW'(NUM_BLOCKS)) begin
                    w_free_clr[b] = 1'b1;
                end else begin
                    stop = 1'b1;
                end
            end
        end
        w_free_more = !stop && !w_last_word;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ffa_pkg::S_INIT: begin
                if (w_last_word) n_state = ffa_pkg::S_IDLE;
            end
            ffa_pkg::S_IDLE: begin
                if (w_accept) n_state = ffa_pkg::S_DECODE;
            end
            ffa_pkg::S_DECODE: begin
                case (r_mode)
                    ffa_pkg::MODE_ALLOC: begin
                        if (r_bytes == 16'd0 || w_alloc_big) n_state = ffa_pkg::S_RESP;
                        else                                 n_state = ffa_pkg::S_DIV;
                    end
                    ffa_pkg::MODE_FREE: begin
                        if (w_free_bad) n_state = ffa_pkg::S_RESP;
                        else            n_state = ffa_pkg::S_DIV;
                    end
                    ffa_pkg::MODE_CLEAR: n_state = ffa_pkg::S_WIPE;
                    default:             n_state = ffa_pkg::S_RESP;
                endcase
            end
            ffa_pkg::S_DIV: begin
                if (w_div_done) begin
                    if (r_mode == ffa_pkg::MODE_ALLOC) n_state = ffa_pkg::S_SCAN;
                    else                               n_state = ffa_pkg::S_FREE;
                end
            end
            ffa_pkg::S_SCAN: begin
                if (w_found)          n_state = ffa_pkg::S_MARK_RD;
                else if (w_last_word) n_state = ffa_pkg::S_RESP;
            end
            ffa_pkg::S_MARK_RD: n_state = ffa_pkg::S_MARK;
            ffa_pkg::S_MARK: begin
                if (r_word == r_end[AW+BW-1:BW]) n_state = ffa_pkg::S_ADDR;
            end
            ffa_pkg::S_ADDR: n_state = ffa_pkg::S_RESP;
            ffa_pkg::S_FREE: begin
                if (!w_free_more) n_state = ffa_pkg::S_RESP;
            end
            ffa_pkg::S_WIPE: begin
                if (w_last_word) n_state = ffa_pkg::S_RESP;
            end
            ffa_pkg::S_RESP: begin
                if (w_take) n_state = ffa_pkg::S_IDLE;
            end
            default: n_state = ffa_pkg::S_INIT;
        endcase
    end

    // memory and divider controls
    always_comb begin
        w_rd_en     = 1'b0;
        w_rd_addr   = r_word + AW'(1);
        w_wr_en     = 1'b0;
        w_wr_addr   = r_word;
        w_wr_data   = '0;
        w_div_start = 1'b0;
        w_div_dvd   = '0;
        case (r_state)
            ffa_pkg::S_INIT, ffa_pkg::S_WIPE: begin
                w_wr_en = 1'b1;
            end
            ffa_pkg::S_DECODE: begin
                if (r_mode == ffa_pkg::MODE_ALLOC) begin
                    w_div_start = (r_bytes != 16'd0) && !w_alloc_big;
                    w_div_dvd   = DW'(32'(r_bytes) + 32'(BLOCK_BYTES - 1));
                end else if (r_mode == ffa_pkg::MODE_FREE) begin
                    w_div_start = !w_free_bad;
                    w_div_dvd   = DW'(w_off);
                end
            end
            ffa_pkg::S_DIV: begin
                w_rd_en = w_div_done;
                if (r_mode == ffa_pkg::MODE_ALLOC) w_rd_addr = '0;
                else                               w_rd_addr = w_q[AW+BW-1:BW];
            end
            ffa_pkg::S_SCAN: begin
                w_rd_en = !w_found && !w_last_word;
            end
            ffa_pkg::S_MARK_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_start[AW+BW-1:BW];
            end
            ffa_pkg::S_MARK: begin
                w_wr_en   = 1'b1;
                w_wr_data = w_rd_data | w_mark_mask;
                w_rd_en   = (r_word != r_end[AW+BW-1:BW]);
            end
            ffa_pkg::S_FREE: begin
                w_wr_en   = 1'b1;
                w_wr_data = w_rd_data & ~w_free_clr;
                w_rd_en   = w_free_more;
            end
            default: begin
                w_rd_en = 1'b0;
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ffa_pkg::S_INIT;
            r_word      <= '0;
            r_heap_base <= ffa_pkg::HEAP_BASE_RST;
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_heap_base <= i_cfg_data;
            end
            // word pointer
            case (r_state)
                ffa_pkg::S_INIT, ffa_pkg::S_WIPE, ffa_pkg::S_SCAN,
                ffa_pkg::S_MARK, ffa_pkg::S_FREE: begin
                    if (w_rd_en || ((r_state == ffa_pkg::S_INIT ||
                                     r_state == ffa_pkg::S_WIPE) && !w_last_word)) begin
                        r_word <= r_word + AW'(1);
                    end
                end
                ffa_pkg::S_DECODE: r_word <= '0;
                ffa_pkg::S_DIV: begin
                    if (w_div_done) r_word <= w_rd_addr;
                end
                ffa_pkg::S_MARK_RD: r_word <= w_rd_addr;
                default: r_word <= r_word;
            endcase
            // output beat register
            if (r_state == ffa_pkg::S_RESP && w_take) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode     <= ffa_pkg::t_mode'(i_s_tuser);
            r_bytes    <= i_s_tdata[15:0];
            r_faddr    <= i_s_tdata[47:16];
            r_res_addr <= '0;
            r_status   <= ffa_pkg::STAT_DONE;
        end
        case (r_state)
            ffa_pkg::S_DECODE: begin
                if (r_mode == ffa_pkg::MODE_ALLOC) begin
                    if (r_bytes == 16'd0) r_status <= ffa_pkg::STAT_ZERO;
                    else if (w_alloc_big) r_status <= ffa_pkg::STAT_NOSPACE;
                end else if (r_mode == ffa_pkg::MODE_FREE && w_free_bad) begin
                    r_status <= ffa_pkg::STAT_IGNORED;
                end
            end
            ffa_pkg::S_DIV: begin
                if (w_div_done) begin
                    r_count <= '0;
                    if (r_mode == ffa_pkg::MODE_ALLOC) begin
                        r_needed <= w_q;
                        r_start  <= '0;
                    end else begin
                        r_start <= w_q;
                    end
                end
            end
            ffa_pkg::S_SCAN: begin
                r_count <= w_scan_count;
                r_start <= w_scan_start;
                r_end   <= w_scan_start + r_needed - XW'(1);
                if (!w_found && w_last_word) r_status <= ffa_pkg::STAT_NOSPACE;
            end
            ffa_pkg::S_MARK_RD: r_offs <= 32'(r_start) * 32'(BLOCK_BYTES);
            ffa_pkg::S_ADDR:    r_res_addr <= r_heap_base + r_offs;
            default: begin
                r_offs <= r_offs;
            end
        endcase
        if (r_state == ffa_pkg::S_RESP && w_take) begin
            r_oaddr <= r_res_addr;
            r_ostat <= r_status;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_oaddr;
    assign o_m_tuser  = r_ostat;

endmodule

`default_nettype wire
